FILE: hdl/dsf_pkg.sv
// Shared constants and types for the damped spring force unit.
package dsf_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_REST    = 2'd0,
    REG_STIFF   = 2'd1,
    REG_DAMP    = 2'd2,
    REG_UNUSED  = 2'd3
  } reg_idx_t;

  localparam int APB_AW = 4;

  // Control that travels with each item through a cell row.
  typedef struct packed {
    logic valid;
    logic zero;
  } dsf_ctl_t;

endpackage

FILE: hdl/dsf_sqrt_cell.sv
// One bit step of the square root, passing radicand and root on.
module dsf_sqrt_cell
  import dsf_pkg::*;
#(
  parameter int SW  = 70,
  parameter int RW  = 35,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [SW-1:0] rad_in,
  input  logic [RW-1:0] root_in,
  output logic [SW-1:0] rad_out,
  output logic [RW-1:0] root_out
);

  logic [RW-1:0]   cand;
  logic [2*RW-1:0] sq;

  // Try setting this bit of the root and keep it when its square still fits.
  always_comb begin
    cand = root_in | (RW'(1) << BIT);
    sq   = {{RW{1'b0}}, cand} * {{RW{1'b0}}, cand};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= rad_in;
      root_out <= ((2*RW)'(rad_in) >= sq) ? cand : root_in;
    end
  end

endmodule

FILE: hdl/dsf_div_cell.sv
// One bit step of the restoring divider, passing remainder and quotient on.
module dsf_div_cell
  import dsf_pkg::*;
#(
  parameter int NW = 52,
  parameter int DW = 35
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW:0]   rem_in,
  input  logic [NW-1:0] num_in,
  input  logic [DW-1:0] den,
  output logic [DW:0]   rem_out,
  output logic [NW-1:0] num_out
);

  logic [DW+1:0] sh;
  logic          ge;

  // Shift one numerator bit into the remainder and subtract when possible.
  always_comb begin
    sh = {rem_in, num_in[NW-1]};
    ge = sh >= {2'b00, den};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? (DW+1)'(sh - {2'b00, den}) : sh[DW:0];
      num_out <= {num_in[NW-2:0], ge};
    end
  end

endmodule

FILE: hdl/damped_spring_force_unit.sv
// Top level of the damped spring force unit: cell rows, APB registers and output stage.
// Pipeline from input transfer to result: 2 difference and square stages,
// 34 square-root cells, 49 divider cells and 6 product and output stages.
// Throughput: one spring per cycle; the whole pipeline advances together whenever the
// output register is free or taken, so a waiting result stalls every stage.
// Reset (rst, synchronous): clears all valid flags and the three registers to zero.
module damped_spring_force_unit
  import dsf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
  // vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z
  input  logic [12*DATA_WIDTH-1:0] s_tdata,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // force_x, force_y, force_z
  output logic [3*DATA_WIDTH-1:0] m_tdata,
  // zero_length, saturated
  output logic [1:0]              m_tuser
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int EW  = W + 1;            // exact differences
  localparam int SW  = 2*EW + 2;         // sum of squares
  localparam int RW  = EW + 1;           // root width
  localparam int NW  = EW + F;           // divider numerator
  localparam int UW  = F + 1;            // unit magnitude, at most 1.0
  localparam int PL  = W + F + 2;        // path for dot products
  localparam int SSW = 2*W + 4;          // stretch plus damping sum
  localparam int NDIV = NW;
  localparam int DEPTH = RW + NDIV;

  // Configuration registers.
  logic [W-2:0] rest_length, stiffness, damping;
  logic         wr;
  reg_idx_t     ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_length <= '0;
      stiffness   <= '0;
      damping     <= '0;
    end else if (wr) begin
      case (ridx)
        REG_REST:  rest_length <= pwdata[W-2:0];
        REG_STIFF: stiffness   <= pwdata[W-2:0];
        REG_DAMP:  damping     <= pwdata[W-2:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_REST:  prdata = 32'(rest_length);
      REG_STIFF: prdata = 32'(stiffness);
      REG_DAMP:  prdata = 32'(damping);
      default:   prdata = '0;
    endcase
  end

  // The pipeline moves when the output register is empty or is being taken.
  logic adv;
  logic out_valid;
  assign adv      = !out_valid || m_tready;
  assign s_tready = adv;

  // Stage 0: differences and squares.
  logic signed [EW-1:0] d0 [3];
  logic signed [EW-1:0] v0 [3];
  logic [SW-1:0]        sq0;
  logic                 val0;

  always_ff @(posedge clk) begin
    if (rst) val0 <= 1'b0;
    else if (adv) val0 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d0[i] <= EW'($signed(s_tdata[(3+i)*W +: W])) - EW'($signed(s_tdata[i*W +: W]));
        v0[i] <= EW'($signed(s_tdata[(9+i)*W +: W])) - EW'($signed(s_tdata[(6+i)*W +: W]));
      end
    end
  end

  logic [2*EW-1:0] sqp [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqp[i] = (2*EW)'($signed(d0[i]) * $signed(d0[i]));
    end
  end

  logic signed [EW-1:0] d1 [3];
  logic signed [EW-1:0] v1 [3];
  logic [2*EW-1:0]      sqr [3];
  logic                 val1;
  always_ff @(posedge clk) begin
    if (rst) val1 <= 1'b0;
    else if (adv) val1 <= val0;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      d1 <= d0;
      v1 <= v0;
      sqr <= sqp;
    end
  end
  assign sq0 = SW'(sqr[0]) + SW'(sqr[1]) + SW'(sqr[2]);

  // Square-root row: payload delay lines travel beside the cells.
  logic [SW-1:0]        rad  [RW+1];
  logic [RW-1:0]        root [RW+1];
  logic signed [EW-1:0] dq   [RW+1][3];
  logic signed [EW-1:0] vq   [RW+1][3];
  logic [RW:0]          vs;

  assign rad[0]  = sq0;
  assign root[0] = '0;
  assign vs[0]   = val1;
  assign dq[0]   = d1;
  assign vq[0]   = v1;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    dsf_sqrt_cell #(.SW(SW), .RW(RW), .BIT(RW-1-k)) u_cell (
      .clk(clk), .en(adv),
      .rad_in(rad[k]), .root_in(root[k]),
      .rad_out(rad[k+1]), .root_out(root[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) vs[k+1] <= 1'b0;
      else if (adv) vs[k+1] <= vs[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dq[k+1] <= dq[k];
        vq[k+1] <= vq[k];
      end
    end
  end

  // Divider rows, one per axis, sharing the length as divisor.
  logic [RW-1:0]        len  [NDIV+1];
  logic signed [EW-1:0] vd   [NDIV+1][3];
  logic [2:0]           dn   [NDIV+1];
  logic [NDIV:0]        vv;
  logic [RW:0]          rem  [3][NDIV+1];
  logic [NW-1:0]        num  [3][NDIV+1];

  assign len[0] = root[RW];
  assign vd[0]  = vq[RW];
  assign vv[0]  = vs[RW];
  for (genvar a = 0; a < 3; a++) begin : g_ax
    logic [EW-1:0] mg;
    assign mg        = dq[RW][a][EW-1] ? EW'(-dq[RW][a]) : EW'(dq[RW][a]);
    assign dn[0][a]  = dq[RW][a][EW-1];
    assign rem[a][0] = '0;
    assign num[a][0] = {mg, {F{1'b0}}};
    for (genvar k = 0; k < NDIV; k++) begin : g_div
      dsf_div_cell #(.NW(NW), .DW(RW)) u_cell (
        .clk(clk), .en(adv), .rem_in(rem[a][k]), .num_in(num[a][k]), .den(len[k]),
        .rem_out(rem[a][k+1]), .num_out(num[a][k+1])
      );
    end
  end
  for (genvar k = 0; k < NDIV; k++) begin : g_dline
    always_ff @(posedge clk) begin
      if (rst) vv[k+1] <= 1'b0;
      else if (adv) vv[k+1] <= vv[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        len[k+1] <= len[k];
        vd[k+1]  <= vd[k];
        dn[k+1]  <= dn[k];
      end
    end
  end

  // Stage A: dot-product terms rv_i * u_i with signs.
  logic [UW-1:0]        ua [3];
  logic [2:0]           una;
  logic [RW-1:0]        lena;
  logic signed [PL-1:0] pa [3];
  logic                 vala;
  always_ff @(posedge clk) begin
    if (rst) vala <= 1'b0;
    else if (adv) vala <= vv[NDIV];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ua[i] <= UW'(num[i][NDIV]);
        pa[i] <= PL'($signed(vd[NDIV][i]) *
                 $signed({1'b0, UW'(num[i][NDIV])}) * (dn[NDIV][i] ? -1 : 1));
      end
      una  <= dn[NDIV];
      lena <= len[NDIV];
    end
  end

  // Stage B: dot sum truncated toward zero, and the signed stretch.
  logic signed [PL+1:0] dsum;
  logic [PL+1:0]        dmag;
  logic                 dneg;
  assign dsum = (PL+2)'(pa[0]) + (PL+2)'(pa[1]) + (PL+2)'(pa[2]);
  assign dneg = dsum[PL+1];
  assign dmag = dneg ? (PL+2)'(-dsum) : dsum;

  logic [PL+1-F:0]      dotm;
  logic                 dotn;
  logic signed [RW:0]   strb;
  logic [UW-1:0]        ub [3];
  logic [2:0]           unb;
  logic                 valb, zerob;
  always_ff @(posedge clk) begin
    if (rst) valb <= 1'b0;
    else if (adv) valb <= vala;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dotm  <= dmag[PL+1:F];
      dotn  <= dneg && (dmag[PL+1:F] != '0);
      strb  <= $signed({1'b0, lena}) - $signed((RW+1)'(rest_length));
      ub    <= ua;
      unb   <= una;
      zerob <= lena == '0;
    end
  end

  // Stage C: the two scalar products.
  logic signed [SSW-1:0] pk, pd;
  logic [SSW-1:0]        pdm;
  logic [UW-1:0]         uc [3];
  logic [2:0]            unc;
  logic                  valc, zeroc;
  assign pdm = SSW'({1'b0, damping} * dotm);
  always_ff @(posedge clk) begin
    if (rst) valc <= 1'b0;
    else if (adv) valc <= valb;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pk    <= SSW'($signed({1'b0, stiffness}) * strb);
      pd    <= dotn ? -$signed(pdm) : $signed(pdm);
      uc    <= ub;
      unc   <= unb;
      zeroc <= zerob;
    end
  end

  // Stage D: sum S, then magnitude and sign.
  logic signed [SSW:0] ssum;
  assign ssum = (SSW+1)'(pk) + (SSW+1)'(pd);
  logic [SSW:0]  smag;
  logic          sneg;
  logic [UW-1:0] ud [3];
  logic [2:0]    und;
  logic          vald, zerod;
  always_ff @(posedge clk) begin
    if (rst) vald <= 1'b0;
    else if (adv) vald <= valc;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sneg  <= ssum[SSW];
      smag  <= ssum[SSW] ? (SSW+1)'(-ssum) : ssum;
      ud    <= uc;
      und   <= unc;
      zerod <= zeroc;
    end
  end

  // Stage E: force magnitudes per axis.
  logic [SSW+UW:0] fm [3];
  logic [2:0]      fneg;
  logic            vale, zeroe;
  always_ff @(posedge clk) begin
    if (rst) vale <= 1'b0;
    else if (adv) vale <= vald;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        fm[i]   <= (SSW+UW+1)'(smag * ud[i]);
        fneg[i] <= sneg != und[i];
      end
      zeroe <= zerod;
    end
  end

  // Output register: shift, saturate, negate.
  logic [SSW+UW-2*F:0] q [3];
  logic [W-1:0]        fo [3];
  logic [2:0]          satv;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i] = fm[i][SSW+UW:2*F];
      if (q[i] > (SSW+UW-2*F+1)'({1'b0, {(W-1){1'b1}}}) + fneg[i]) begin
        satv[i] = 1'b1;
        fo[i]   = fneg[i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        satv[i] = 1'b0;
        fo[i]   = fneg[i] ? W'(-q[i]) : W'(q[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vale;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= zeroe ? '0 : {fo[2], fo[1], fo[0]};
      m_tuser <= zeroe ? 2'b01 : {|satv, 1'b0};
    end
  end
  assign m_tvalid = out_valid;

`ifndef ASSERT_OFF
  // A coincident-particle result never reports clipping.
  a_zero_nosat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("zero_length and saturated both set");
  // A zero-length result carries a zero force.
  a_zero_force: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("nonzero force on zero length");
  // The pipeline stalls only when a result is waiting and not taken.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("pipeline stalled without back-pressure");
`endif

endmodule
